FILE: design/ssp_pkg.sv
// Package for the seekable stream prefetch FIFO.
// Holds sizes, action and status codes, and the command type passed front to back.
// No dependencies.
`default_nettype none

package ssp_pkg;

  // Ring buffer geometry
  localparam int unsigned DEPTH = 262144;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // Field widths
  localparam int unsigned POS_W = 48;
  localparam int unsigned THR_W = 19;
  localparam int unsigned TGT_W = POS_W + 2;

  // Refill threshold after reset
  localparam logic [THR_W-1:0] REFILL_THR_RST = THR_W'(204799);

  // Command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Action codes on the input
  localparam logic [2:0] ACT_WRITE   = 3'd0;
  localparam logic [2:0] ACT_READ    = 3'd1;
  localparam logic [2:0] ACT_SEEK    = 3'd2;
  localparam logic [2:0] ACT_SET_EOF = 3'd3;
  localparam logic [2:0] ACT_CLEAR   = 3'd4;

  // Seek modes
  localparam logic [1:0] SM_START   = 2'd0;
  localparam logic [1:0] SM_CURRENT = 2'd1;
  localparam logic [1:0] SM_END     = 2'd2;

  // Configuration register indexes
  localparam logic CFG_FILE_SIZE = 1'b0;
  localparam logic CFG_THRESHOLD = 1'b1;

  typedef enum logic [2:0] {
    OP_WRITE,
    OP_READ,
    OP_SEEK,
    OP_SET_EOF,
    OP_CLEAR,
    OP_NOP
  } op_e;

  // Base operand of the seek target adder
  typedef enum logic [1:0] {
    BASE_ZERO,
    BASE_POS,
    BASE_SIZE
  } base_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_FULL   = 3'd1,
    ST_EMPTY  = 3'd2,
    ST_AT_EOF = 3'd3,
    ST_REJECT = 3'd4
  } status_e;

  typedef enum logic {
    BK_EXEC,
    BK_RDATA
  } bk_state_e;

  // Classified command
  typedef struct packed {
    op_e              op;
    logic [7:0]       data;
    logic             last;
    logic             eof_val;
    base_e            base;
    logic             reject;
    logic [TGT_W-1:0] addend;
  } cmd_t;

endpackage

`default_nettype wire

FILE: design/ssp_front.sv
// Front end: decodes an input beat into a classified command for the queue.
// Depends on ssp_pkg.
`default_nettype none

module ssp_front import ssp_pkg::*; (
  input  wire logic              in_valid_i,
  output      logic              in_ready_o,
  input  wire logic [2:0]        action_i,
  input  wire logic [7:0]        data_byte_i,
  input  wire logic              last_byte_i,
  input  wire logic [1:0]        seek_mode_i,
  input  wire logic [POS_W-1:0]  seek_offset_i,
  input  wire logic              eof_value_i,
  output      logic              cmd_valid_o,
  input  wire logic              cmd_ready_i,
  output      cmd_t              cmd_o
);

  logic [TGT_W-1:0] off_ext;

  // Hand the beat straight to the queue
  assign cmd_valid_o = in_valid_i;
  assign in_ready_o  = cmd_ready_i;

  assign off_ext = {{(TGT_W - POS_W){seek_offset_i[POS_W-1]}}, seek_offset_i};

  // Classify action and prepare the seek adder operands
  always_comb begin
    cmd_o         = '0;
    cmd_o.data    = data_byte_i;
    cmd_o.last    = last_byte_i;
    cmd_o.eof_val = eof_value_i;
    cmd_o.base    = BASE_ZERO;
    cmd_o.reject  = 1'b0;
    cmd_o.addend  = off_ext;

    unique case (action_i)
      ACT_WRITE:   cmd_o.op = OP_WRITE;
      ACT_READ:    cmd_o.op = OP_READ;
      ACT_SEEK:    cmd_o.op = OP_SEEK;
      ACT_SET_EOF: cmd_o.op = OP_SET_EOF;
      ACT_CLEAR:   cmd_o.op = OP_CLEAR;
      default:     cmd_o.op = OP_NOP;
    endcase

    // From end: size - off - 1 is size + ~off
    unique case (seek_mode_i)
      SM_START:   cmd_o.base = BASE_ZERO;
      SM_CURRENT: cmd_o.base = BASE_POS;
      SM_END: begin
        cmd_o.base   = BASE_SIZE;
        cmd_o.addend = ~off_ext;
      end
      default:    cmd_o.reject = 1'b1;
    endcase
  end

endmodule

`default_nettype wire

FILE: design/ssp_cmd_queue.sv
// Short command queue that decouples the front end from the back end.
// Depends on ssp_pkg.
`default_nettype none

module ssp_cmd_queue import ssp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_valid_i,
  output      logic push_ready_o,
  input  wire cmd_t push_cmd_i,
  output      logic pop_valid_o,
  input  wire logic pop_ready_i,
  output      cmd_t pop_cmd_o
);

  cmd_t              entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d;
  logic [QPTR_W-1:0] rptr_q, rptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push, pop;

  assign push_ready_o = cnt_q != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_cmd_o    = entry_q[rptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Advance pointers and count
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop) begin
      rptr_d = (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Store the beat
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

FILE: design/ssp_back.sv
// Back end: byte store, pointers, file position, seek and refill logic, result register.
// Depends on ssp_pkg.
`default_nettype none

module ssp_back import ssp_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_index_i,
  input  wire logic [POS_W-1:0] cfg_data_i,
  input  wire logic             cmd_valid_i,
  output      logic             cmd_ready_o,
  input  wire cmd_t             cmd_i,
  output      logic             out_valid_o,
  input  wire logic             out_ready_i,
  output      logic [7:0]       read_data_o,
  output      logic [2:0]       status_o,
  output      logic [POS_W-1:0] position_o,
  output      logic             refill_request_o,
  output      logic             seek_request_o,
  output      logic [CNT_W-1:0] unread_count_o
);

  // Byte store, contents undefined until written
  logic [7:0]       mem_q [DEPTH];
  logic [7:0]       mem_rdata_q;
  logic             mem_we, mem_re;

  bk_state_e        state_q, state_d;

  // Configuration
  logic [POS_W-1:0] size_q, size_d;
  logic [THR_W-1:0] thr_q, thr_d;

  // Buffer and file state
  logic [PTR_W-1:0] wptr_q, wptr_d;
  logic [PTR_W-1:0] rptr_q, rptr_d;
  logic [CNT_W-1:0] held_q, held_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic             eof_q, eof_d;
  logic             pend_q, pend_d;
  logic             seeking_q, seeking_d;
  logic             rd_refill_q, rd_refill_d;

  // Result register
  logic             out_valid_q, out_valid_d;
  logic [7:0]       rd_data_q, rd_data_d;
  status_e          status_q, status_d;
  logic [POS_W-1:0] res_pos_q, res_pos_d;
  logic             refill_q, refill_d;
  logic             seekreq_q, seekreq_d;
  logic [CNT_W-1:0] unread_q, unread_d;

  logic             pop, read_hit, full, empty, above;
  logic [CNT_W-1:0] held_chk, free_cnt;
  logic [TGT_W-1:0] base_val, target;
  logic             seek_bad;

  assign full     = held_q == CNT_W'(DEPTH);
  assign empty    = held_q == '0;
  assign read_hit = (cmd_i.op == OP_READ) && !empty;

  // Take a command only in the execute state, when the result slot is empty or frees up this cycle
  assign cmd_ready_o = (state_q == BK_EXEC) && (!out_valid_q || out_ready_i);
  assign pop         = cmd_valid_i && cmd_ready_o;
  assign mem_re      = pop && read_hit;

  // Free space check on the count after the action
  always_comb begin
    if (cmd_i.op == OP_READ) begin
      held_chk = held_q - 1'b1;
    end else if (full) begin
      held_chk = held_q;
    end else begin
      held_chk = held_q + 1'b1;
    end
  end
  assign free_cnt = CNT_W'(DEPTH) - held_chk;
  assign above    = free_cnt > CNT_W'(thr_q);

  // Seek target and range check
  always_comb begin
    case (cmd_i.base)
      BASE_POS:  base_val = TGT_W'(pos_q);
      BASE_SIZE: base_val = TGT_W'(size_q);
      default:   base_val = '0;
    endcase
  end
  assign target   = base_val + cmd_i.addend;
  assign seek_bad = cmd_i.reject || target[TGT_W-1]
                 || (target[TGT_W-2:0] > {1'b0, size_q});

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_EXEC:  if (pop && read_hit) state_d = BK_RDATA;
      BK_RDATA: state_d = BK_EXEC;
      default:  state_d = BK_EXEC;
    endcase
  end

  // Execute the command and form the result
  always_comb begin
    size_d      = size_q;
    thr_d       = thr_q;
    wptr_d      = wptr_q;
    rptr_d      = rptr_q;
    held_d      = held_q;
    pos_d       = pos_q;
    eof_d       = eof_q;
    pend_d      = pend_q;
    seeking_d   = seeking_q;
    rd_refill_d = rd_refill_q;
    mem_we      = 1'b0;

    out_valid_d = out_valid_q && !out_ready_i;
    rd_data_d   = rd_data_q;
    status_d    = status_q;
    res_pos_d   = res_pos_q;
    refill_d    = refill_q;
    seekreq_d   = seekreq_q;
    unread_d    = unread_q;

    if (cfg_we_i) begin
      if (cfg_index_i == CFG_FILE_SIZE) begin
        size_d = cfg_data_i;
      end else if (cfg_index_i == CFG_THRESHOLD) begin
        thr_d = cfg_data_i[THR_W-1:0];
      end
    end

    if (state_q == BK_RDATA) begin
      // Deliver the byte fetched last cycle
      out_valid_d = 1'b1;
      rd_data_d   = mem_rdata_q;
      status_d    = ST_OK;
      res_pos_d   = pos_q;
      refill_d    = rd_refill_q;
      seekreq_d   = 1'b0;
      unread_d    = held_q;
    end else if (pop) begin
      rd_data_d = '0;
      status_d  = ST_OK;
      refill_d  = 1'b0;
      seekreq_d = 1'b0;
      case (cmd_i.op)
        OP_WRITE: begin
          if (!full) begin
            mem_we = 1'b1;
            wptr_d = (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
            held_d = held_q + 1'b1;
          end else begin
            status_d = ST_FULL;
          end
          if (cmd_i.last) begin
            pend_d = 1'b0;
            if (seeking_q) begin
              seeking_d = 1'b0;
            end else if (!eof_q && above) begin
              pend_d   = 1'b1;
              refill_d = 1'b1;
            end
          end
        end
        OP_READ: begin
          if (empty) begin
            if (eof_q) begin
              status_d = ST_AT_EOF;
            end else begin
              pend_d   = 1'b1;
              refill_d = 1'b1;
              status_d = ST_EMPTY;
            end
          end else begin
            rptr_d      = (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
            held_d      = held_q - 1'b1;
            pos_d       = pos_q + 1'b1;
            rd_refill_d = !eof_q && !pend_q && above;
            if (rd_refill_d) begin
              pend_d = 1'b1;
            end
          end
        end
        OP_SEEK: begin
          if (seek_bad) begin
            status_d = ST_REJECT;
          end else begin
            wptr_d    = '0;
            rptr_d    = '0;
            held_d    = '0;
            eof_d     = 1'b0;
            pend_d    = 1'b0;
            seeking_d = 1'b1;
            pos_d     = target[POS_W-1:0];
            seekreq_d = 1'b1;
          end
        end
        OP_SET_EOF: eof_d = cmd_i.eof_val;
        OP_CLEAR: begin
          wptr_d    = '0;
          rptr_d    = '0;
          held_d    = '0;
          pos_d     = '0;
          eof_d     = 1'b0;
          pend_d    = 1'b0;
          seeking_d = 1'b0;
        end
        default: ;
      endcase
      res_pos_d = pos_d;
      unread_d  = held_d;
      // A read that hits posts its result in the next cycle, once the byte is read
      out_valid_d = !read_hit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_EXEC;
      size_q      <= '0;
      thr_q       <= REFILL_THR_RST;
      wptr_q      <= '0;
      rptr_q      <= '0;
      held_q      <= '0;
      pos_q       <= '0;
      eof_q       <= 1'b0;
      pend_q      <= 1'b0;
      seeking_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      size_q      <= size_d;
      thr_q       <= thr_d;
      wptr_q      <= wptr_d;
      rptr_q      <= rptr_d;
      held_q      <= held_d;
      pos_q       <= pos_d;
      eof_q       <= eof_d;
      pend_q      <= pend_d;
      seeking_q   <= seeking_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload and read refill flag
  always_ff @(posedge clk_i) begin
    rd_refill_q <= rd_refill_d;
    rd_data_q   <= rd_data_d;
    status_q    <= status_d;
    res_pos_q   <= res_pos_d;
    refill_q    <= refill_d;
    seekreq_q   <= seekreq_d;
    unread_q    <= unread_d;
  end

  // Byte store ports
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wptr_q] <= cmd_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      mem_rdata_q <= mem_q[rptr_q];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign read_data_o      = rd_data_q;
  assign status_o         = status_q;
  assign position_o       = res_pos_q;
  assign refill_request_o = refill_q;
  assign seek_request_o   = seekreq_q;
  assign unread_count_o   = unread_q;

  // Count never exceeds the store
  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= CNT_W'(DEPTH))
    else $error("held count above depth");

  // Empty or full store means the pointers meet
  a_ptr_meet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (empty || full) |-> (wptr_q == rptr_q))
    else $error("pointers disagree with count");

  // The byte fetch cycle always finds the result slot free
  a_rdata_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_RDATA) |-> !out_valid_q)
    else $error("result slot busy during byte fetch");

endmodule

`default_nettype wire

FILE: design/seekable_stream_prefetch_fifo.sv
// Seekable stream prefetch FIFO, top level: front decoder, command queue, back end.
// A beat is registered in the command queue, then executed into the result register; a read
// that delivers a byte also passes the registered read port of the byte store. Throughput:
// one beat per cycle unless the queue or result slot stalls; no command is taken in the byte
// fetch state. Reset clears control state at once; the byte store has no clearing pass.
// Depends on ssp_pkg, ssp_front, ssp_cmd_queue, ssp_back.
`default_nettype none

module seekable_stream_prefetch_fifo import ssp_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_index_i,
  input  wire logic [POS_W-1:0] cfg_data_i,
  input  wire logic             in_valid_i,
  output      logic             in_ready_o,
  input  wire logic [2:0]       action_i,
  input  wire logic [7:0]       data_byte_i,
  input  wire logic             last_byte_i,
  input  wire logic [1:0]       seek_mode_i,
  input  wire logic [POS_W-1:0] seek_offset_i,
  input  wire logic             eof_value_i,
  output      logic             out_valid_o,
  input  wire logic             out_ready_i,
  output      logic [7:0]       read_data_o,
  output      logic [2:0]       status_o,
  output      logic [POS_W-1:0] position_o,
  output      logic             refill_request_o,
  output      logic             seek_request_o,
  output      logic [CNT_W-1:0] unread_count_o
);

  logic fr_valid, fr_ready;
  cmd_t fr_cmd;
  logic bk_valid, bk_ready;
  cmd_t bk_cmd;

  ssp_front u_front (
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .data_byte_i   (data_byte_i),
    .last_byte_i   (last_byte_i),
    .seek_mode_i   (seek_mode_i),
    .seek_offset_i (seek_offset_i),
    .eof_value_i   (eof_value_i),
    .cmd_valid_o   (fr_valid),
    .cmd_ready_i   (fr_ready),
    .cmd_o         (fr_cmd)
  );

  ssp_cmd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_cmd_i   (fr_cmd),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_cmd_o    (bk_cmd)
  );

  ssp_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .cmd_valid_i      (bk_valid),
    .cmd_ready_o      (bk_ready),
    .cmd_i            (bk_cmd),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .read_data_o      (read_data_o),
    .status_o         (status_o),
    .position_o       (position_o),
    .refill_request_o (refill_request_o),
    .seek_request_o   (seek_request_o),
    .unread_count_o   (unread_count_o)
  );

endmodule

`default_nettype wire
